FILE: rtl/time_deinterleaver_16_branch_macros.svh
// Assertion macros for the deinterleaver module.
`ifndef TIME_DEINTERLEAVER_16_BRANCH_MACROS_SVH
`define TIME_DEINTERLEAVER_16_BRANCH_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define TDI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deinterleaver check failed");

// Consequent must hold in the cycle after the antecedent.
`define TDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deinterleaver check failed");

`else

`define TDI_ASSERT_SAME(label, clk, rst, ante, cons)
`define TDI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/tdi_pkg.sv
package tdi_pkg;

   localparam int SOFT_W           = 8;
   localparam int BRANCHES         = 16;
   localparam int ROW_W            = 4;
   localparam int MAX_FRAGMENT_DEF = 32768;

   localparam int FRAG_SIZE_W = 16;
   localparam logic [FRAG_SIZE_W-1:0] FRAG_SIZE_RESET = 16'd32768;

   localparam int FILL_W = 5;
   localparam logic [FILL_W-1:0] FILL_DONE = 5'd16;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_FRAGMENT_SIZE = 1'b0;

   // Row offset applied to the current row, indexed by position mod 16.
   localparam logic [ROW_W-1:0] ROW_OFFSET [BRANCHES] = '{
      4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
      4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
   };

endpackage

FILE: rtl/tdi_channels.sv
interface tdi_req_if;
   import tdi_pkg::*;

   logic              valid;
   logic              ready;
   logic [SOFT_W-1:0] soft_bit;

   modport source (output valid, output soft_bit, input ready);
   modport sink (input valid, input soft_bit, output ready);
endinterface

interface tdi_rsp_if;
   import tdi_pkg::*;

   logic              valid;
   logic              ready;
   logic [SOFT_W-1:0] soft_bit_out;
   logic              fragment_end;

   modport source (output valid, output soft_bit_out, output fragment_end, input ready);
   modport sink (input valid, input soft_bit_out, input fragment_end, output ready);
endinterface

FILE: rtl/time_deinterleaver_16_branch.sv
// Sixteen-branch convolutional time deinterleaver for 8-bit soft bits. Each
// transfer on the request channel carries one soft bit; the block tracks its
// position inside a fragment of fragment_size bits (register 0, reset 32768,
// zero acts as 1, values above MAX_FRAGMENT act as MAX_FRAGMENT) and a current
// row from 0 to 15. For each bit it returns the bit stored at the same position
// in row (current row + offset[position mod 16]) mod 16 and then stores the new
// bit in the current row. No response transfer is made during the first 16
// fragments after reset; after that every request gives exactly one response,
// with fragment_end set on the last bit of a fragment. The block sustains one
// bit per clock cycle unless the response channel stalls: the delay store is a
// single memory of 16 x MAX_FRAGMENT bytes (MAX_FRAGMENT rounded up to a power
// of two) with one read and one write port, and each bit costs one read and
// one write of it in the cycle of its transfer. A response passes the memory
// read register, then the output register. The store is not cleared after
// reset, so the block is ready at once; the fill phase guarantees every
// location is written before it is read unless fragment_size is later raised.
module time_deinterleaver_16_branch #(
   parameter int MAX_FRAGMENT = tdi_pkg::MAX_FRAGMENT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tdi_req_if.sink                         req_chan,
   tdi_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tdi_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tdi_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tdi_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   import tdi_pkg::*;

`include "time_deinterleaver_16_branch_macros.svh"

   localparam int POS_W  = $clog2(MAX_FRAGMENT);
   localparam int LEN_W  = POS_W + 1;
   localparam int ADDR_W = ROW_W + POS_W;
   localparam int DEPTH  = 2 ** ADDR_W;

   // Configuration register.
   logic [FRAG_SIZE_W-1:0] frag_size_ff, frag_size_in;
   logic                   csr_write;

   // Fragment tracking state.
   logic [POS_W-1:0]  bit_position_ff, bit_position_in;
   logic [ROW_W-1:0]  current_row_ff, current_row_in;
   logic [FILL_W-1:0] fill_count_ff, fill_count_in;

   // Memory read stage and output register.
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_last_ff, s1_last_in;
   logic              out_valid_ff, out_valid_in;
   logic [SOFT_W-1:0] out_data_ff, out_data_in;
   logic              out_end_ff, out_end_in;

   logic              accept;
   logic              advance;
   logic              emit;
   logic              last_bit;
   logic [LEN_W-1:0]  eff_len;
   logic [LEN_W-1:0]  next_count;
   logic [ROW_W-1:0]  read_row;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [SOFT_W-1:0] rd_data;

   // Configuration port. Writes take effect at the access phase; the port
   // never waits.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      frag_size_in = frag_size_ff;
      csr_prdata   = '0;
      unique case (csr_paddr[2])
         CSR_IDX_FRAGMENT_SIZE: begin
            csr_prdata = CSR_DATA_W'(frag_size_ff);
            if (csr_write) begin
               frag_size_in = csr_pwdata[FRAG_SIZE_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // Effective fragment length: a size of zero behaves as one, and a size
   // beyond the store depth is clamped to it.
   always_comb begin
      if (frag_size_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if ({1'b0, frag_size_ff} > (FRAG_SIZE_W + 1)'(MAX_FRAGMENT)) begin
         eff_len = LEN_W'(MAX_FRAGMENT);
      end else begin
         eff_len = LEN_W'(frag_size_ff);
      end
   end

   // The request side moves whenever the read stage is empty or can hand its
   // result on to the output register in this cycle.
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign emit       = (fill_count_ff >= FILL_DONE);
   assign next_count = {1'b0, bit_position_ff} + LEN_W'(1);
   // A fragment size lowered below the current position ends the fragment
   // on the current bit.
   assign last_bit   = (next_count >= eff_len);

   assign read_row = current_row_ff + ROW_OFFSET[bit_position_ff[ROW_W-1:0]];
   assign rd_addr  = {read_row, bit_position_ff};
   assign wr_addr  = {current_row_ff, bit_position_ff};

   // When the offset is zero the read and the write hit the same location;
   // the memory returns the old contents, which is the delayed bit we want.
   tdi_ram #(
      .WIDTH (SOFT_W),
      .DEPTH (DEPTH)
   ) u_delay_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_chan.soft_bit),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      bit_position_in = bit_position_ff;
      current_row_in  = current_row_ff;
      fill_count_in   = fill_count_ff;
      if (accept) begin
         if (last_bit) begin
            bit_position_in = '0;
            current_row_in  = current_row_ff + ROW_W'(1);
            if (!emit) begin
               fill_count_in = fill_count_ff + FILL_W'(1);
            end
         end else begin
            bit_position_in = next_count[POS_W-1:0];
         end
      end
   end

   // The memory data register holds its value while no new bit is taken, so
   // a stalled read stage keeps its result without a copy.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_last_in   = s1_last_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_end_in   = out_end_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
         out_data_in  = rd_data;
         out_end_in   = s1_last_ff;
         s1_valid_in  = 1'b0;
      end
      if (accept) begin
         s1_valid_in = emit;
         s1_last_in  = last_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frag_size_ff    <= FRAG_SIZE_RESET;
         bit_position_ff <= '0;
         current_row_ff  <= '0;
         fill_count_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         frag_size_ff    <= frag_size_in;
         bit_position_ff <= bit_position_in;
         current_row_ff  <= current_row_in;
         fill_count_ff   <= fill_count_in;
         s1_valid_ff     <= s1_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff  <= s1_last_in;
      out_data_ff <= out_data_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.soft_bit_out = out_data_ff;
   assign rsp_chan.fragment_end = out_end_ff;

   // A bit taken during the fill phase must never reach the read stage.
   `TDI_ASSERT_NEXT(a_fill_silent, clock, reset, accept && !emit, !s1_valid_ff)

   // The end of a fragment restarts the position and steps the row.
   `TDI_ASSERT_NEXT(a_row_step, clock, reset, accept && last_bit,
      (bit_position_ff == '0) && (current_row_ff == $past(current_row_ff) + ROW_W'(1)))

   // The fill counter saturates once all rows hold data.
   `TDI_ASSERT_SAME(a_fill_sat, clock, reset, 1'b1, fill_count_ff <= FILL_DONE)

endmodule

FILE: rtl/tdi_ram.sv
module tdi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
